[hdl/preemptive_priority_scheduler_macros.svh]
// Assertion macros for the preemptive priority scheduler.
// Taken in by the top level; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PPSCH_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PPSCH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ppsch_pkg.sv]
// Shared widths, controller states and command/status bundles of the scheduler.
// No dependencies.
package ppsch_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int ARRIVAL_W     = 16;
   localparam int BURST_W       = 12;
   localparam int PRIO_W        = 8;
   localparam int PINDEX_W      = 6;
   localparam int OUT_TIME_W    = 18;
   localparam int SUM_W         = 24;
   // internal time: max arrival plus 64 full bursts fits in 19 bits
   localparam int TIME_W        = 19;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAIT,
      ST_TICK,
      ST_FIN,
      ST_EMIT
   } ppsch_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic scan_clr;
      logic tick;
      logic fin;
      logic emit;
      logic clear;
   } ppsch_cmd_type;

   typedef struct packed {
      logic last_issue;
      logic found;
      logic complete;
      logic out_free;
      logic run_last;
   } ppsch_sts_type;

endpackage

[hdl/ppsch_ctrl.sv]
// Controller state machine of the scheduler: sequences load, table scan,
// tick update and result emission. Depends on ppsch_pkg.
module ppsch_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_process,
   output logic                    req_ready,
   input  ppsch_pkg::ppsch_sts_type sts,
   output ppsch_pkg::ppsch_cmd_type cmd
);
   import ppsch_pkg::*;

   ppsch_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.scan_clr = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_process) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            state_in = ST_TICK;
         end
         ST_TICK: begin
            cmd.tick     = 1'b1;
            cmd.scan_clr = 1'b1;
            if (sts.found && sts.complete) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.scan_clr = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.run_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/ppsch_dp.sv]
// Datapath of the scheduler: process table memory, scan compare, time and
// sum registers, result register. Depends on ppsch_pkg.
module ppsch_dp #(
   parameter int MAX_PROCS = ppsch_pkg::MAX_PROCS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppsch_pkg::ppsch_cmd_type             cmd,
   output ppsch_pkg::ppsch_sts_type             sts,
   input  logic [ppsch_pkg::ARRIVAL_W-1:0]      req_arrival_time,
   input  logic [ppsch_pkg::BURST_W-1:0]        req_burst_time,
   input  logic [ppsch_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ppsch_pkg::PINDEX_W-1:0]       rsp_process_index,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_start_time,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_finish_time,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_turnaround,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_waiting,
   output logic [ppsch_pkg::SUM_W-1:0]          rsp_total_turnaround,
   output logic [ppsch_pkg::SUM_W-1:0]          rsp_total_waiting,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_idle_total,
   output logic                                 rsp_last_result
);
   import ppsch_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
      logic [PRIO_W-1:0]    prio;
      logic [BURST_W-1:0]   remaining;
      logic [TIME_W-1:0]    start;
   } entry_type;

   // process table, one row per loaded process
   entry_type mem [MAX_PROCS];

   entry_type            rd_data_ff;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   entry_type            best_ff, best_in, best_upd;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic [CNT_W-1:0]     completed_ff, completed_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    last_busy_ff, last_busy_in;
   logic [TIME_W-1:0]    gap_ff;
   logic [TIME_W-1:0]    tat_ff;
   logic [SUM_W-1:0]     sum_tat_ff, sum_tat_in;
   logic [SUM_W-1:0]     sum_wt_ff, sum_wt_in;
   logic [OUT_TIME_W-1:0] sum_idle_ff, sum_idle_in;
   logic                 rsp_valid_ff;

   logic                 room;
   logic                 load_en;
   logic [BURST_W-1:0]   burst_eff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic                 take;
   logic                 first_run;
   logic [TIME_W-1:0]    now_inc;
   logic [TIME_W-1:0]    wt;
   logic [CNT_W-1:0]     completed_inc;
   logic [SUM_W-1:0]     sum_tat_add;
   logic [SUM_W-1:0]     sum_wt_add;

   assign room      = loaded_ff < CNT_W'(MAX_PROCS);
   assign load_en   = cmd.load && room;
   assign burst_eff = (req_burst_time == '0) ? BURST_W'(1) : req_burst_time;
   assign now_inc   = now_ff + TIME_W'(1);
   assign first_run = best_ff.remaining == best_ff.burst;
   assign wt        = tat_ff - TIME_W'(best_ff.burst);
   assign completed_inc = completed_ff + CNT_W'(1);
   // running totals including the completion being emitted
   assign sum_tat_add = sum_tat_ff + SUM_W'(tat_ff);
   assign sum_wt_add  = sum_wt_ff + SUM_W'(wt);

   // candidate test on the row read last cycle
   assign take = cmp_vld_ff && (rd_data_ff.remaining != '0) &&
                 (TIME_W'(rd_data_ff.arrival) <= now_ff) &&
                 (!found_ff || (rd_data_ff.prio < best_ff.prio));

   always_comb begin
      best_upd           = best_ff;
      best_upd.remaining = best_ff.remaining - BURST_W'(1);
      if (first_run) begin
         best_upd.start = now_ff;
      end
   end

   always_comb begin
      wr_en   = load_en || (cmd.tick && found_ff);
      wr_addr = best_idx_ff;
      wr_data = best_upd;
      if (load_en) begin
         wr_addr           = loaded_ff[IDX_W-1:0];
         wr_data.arrival   = req_arrival_time;
         wr_data.burst     = burst_eff;
         wr_data.prio      = req_priority_req;
         wr_data.remaining = burst_eff;
         wr_data.start     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   always_comb begin
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      loaded_in    = loaded_ff;
      completed_in = completed_ff;
      now_in       = now_ff;
      last_busy_in = last_busy_ff;
      sum_tat_in   = sum_tat_ff;
      sum_wt_in    = sum_wt_ff;
      sum_idle_in  = sum_idle_ff;

      if (cmd.scan_clr) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else if (cmd.issue) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      if (take) begin
         found_in    = 1'b1;
         best_in     = rd_data_ff;
         best_idx_in = cmp_idx_ff;
      end
      if (load_en) begin
         loaded_in = loaded_ff + CNT_W'(1);
      end
      if (cmd.tick) begin
         now_in = now_inc;
         if (found_ff) begin
            best_in      = best_upd;
            last_busy_in = now_inc;
            if (first_run) begin
               sum_idle_in = sum_idle_ff + gap_ff[OUT_TIME_W-1:0];
            end
         end
      end
      if (cmd.emit) begin
         completed_in = completed_inc;
         sum_tat_in   = sum_tat_add;
         sum_wt_in    = sum_wt_add;
      end
      if (cmd.clear) begin
         loaded_in    = '0;
         completed_in = '0;
         now_in       = '0;
         last_busy_in = '0;
         sum_tat_in   = '0;
         sum_wt_in    = '0;
         sum_idle_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         found_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         loaded_ff    <= '0;
         completed_ff <= '0;
         now_ff       <= '0;
         last_busy_ff <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         sum_idle_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         found_ff     <= found_in;
         cmp_vld_ff   <= cmd.issue;
         loaded_ff    <= loaded_in;
         completed_ff <= completed_in;
         now_ff       <= now_in;
         last_busy_ff <= last_busy_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         sum_idle_ff  <= sum_idle_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      cmp_idx_ff  <= scan_idx_ff;
      gap_ff      <= now_ff - last_busy_ff;
      if (cmd.fin) begin
         tat_ff <= now_ff - TIME_W'(best_ff.arrival);
      end
      if (cmd.emit) begin
         rsp_process_index    <= PINDEX_W'(best_idx_ff);
         rsp_start_time       <= best_ff.start[OUT_TIME_W-1:0];
         rsp_finish_time      <= now_ff[OUT_TIME_W-1:0];
         rsp_turnaround       <= tat_ff[OUT_TIME_W-1:0];
         rsp_waiting          <= wt[OUT_TIME_W-1:0];
         rsp_total_turnaround <= sum_tat_add;
         rsp_total_waiting    <= sum_wt_add;
         rsp_idle_total       <= sum_idle_ff;
         rsp_last_result      <= completed_inc == loaded_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.last_issue = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == loaded_ff;
      sts.found      = found_ff;
      sts.complete   = best_ff.remaining == BURST_W'(1);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.run_last   = completed_inc == loaded_ff;
   end

endmodule

[hdl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler, top level: controller plus datapath.
// Depends on ppsch_pkg, ppsch_ctrl, ppsch_dp and the assertion macro header.
//
// Load one process per req_ beat (arrival tick, burst, priority); a beat
// with req_last_process set starts the run on the loaded set. Loads beyond
// MAX_PROCS are dropped, but their last flag still starts the run; a zero
// burst counts as one tick. The run steps simulated time one tick at a
// time and on each tick executes the arrived, unfinished process with the
// smallest priority value, lowest load index on a tie. Every completion
// gives one rsp_ beat in completion order, carrying start, finish,
// turnaround and waiting times, running totals and the accumulated idle
// gap before first runs; rsp_last_result marks the final one, after which
// the block is empty and takes the next set.
// Timing: the run handles every simulated tick, busy or idle, the same
// way: the table sits in a memory with a single read port and is
// scanned one row per cycle, then a wait state drains the compare and
// the tick state writes back the winner. Each completion adds a
// turnaround state, then a totals state, plus any stall while the previous
// result beat is still untaken. req_ready is low for the whole run.
`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = ppsch_pkg::MAX_PROCS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ppsch_pkg::ARRIVAL_W-1:0]      req_arrival_time,
   input  logic [ppsch_pkg::BURST_W-1:0]        req_burst_time,
   input  logic [ppsch_pkg::PRIO_W-1:0]         req_priority_req,
   input  logic                                 req_last_process,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ppsch_pkg::PINDEX_W-1:0]       rsp_process_index,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_start_time,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_finish_time,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_turnaround,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_waiting,
   output logic [ppsch_pkg::SUM_W-1:0]          rsp_total_turnaround,
   output logic [ppsch_pkg::SUM_W-1:0]          rsp_total_waiting,
   output logic [ppsch_pkg::OUT_TIME_W-1:0]     rsp_idle_total,
   output logic                                 rsp_last_result
);
   import ppsch_pkg::*;

   ppsch_cmd_type cmd;
   ppsch_sts_type sts;

   // sequence load, scan, tick update and emit
   ppsch_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_process (req_last_process),
      .req_ready        (req_ready),
      .sts              (sts),
      .cmd              (cmd)
   );

   // hold the process table, time, totals and the result register
   ppsch_dp #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_arrival_time     (req_arrival_time),
      .req_burst_time       (req_burst_time),
      .req_priority_req     (req_priority_req),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_process_index    (rsp_process_index),
      .rsp_start_time       (rsp_start_time),
      .rsp_finish_time      (rsp_finish_time),
      .rsp_turnaround       (rsp_turnaround),
      .rsp_waiting          (rsp_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_idle_total       (rsp_idle_total),
      .rsp_last_result      (rsp_last_result)
   );

   // a new result never overwrites an untaken beat
   `PPSCH_ASSERT_NOW(a_emit_into_free_slot, clock, reset, cmd.emit, !rsp_valid || rsp_ready, "result register overwritten while beat pending")

   // a result beat only appears after an emit command
   `PPSCH_ASSERT_NOW(a_rsp_from_emit, clock, reset, $rose(rsp_valid), $past(cmd.emit), "result beat without emit")

   // the last load starts the run and closes the input
   `PPSCH_ASSERT_NEXT(a_last_load_starts_run, clock, reset, req_valid && req_ready && req_last_process, !req_ready, "input still open after last load")

endmodule
